// ===== hw/rtl/swmb_pkg.sv =====
`default_nettype none
package swmb_pkg;
	localparam int unsigned MAX_HEIGHT = 4096;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_CWEIGHT = 2'd1,
		REG_WIDTH = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic       func;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} request_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [12:0] data;
	} cfg_write_t;
endpackage
`default_nettype wire

// ===== hw/rtl/swmb_if.sv =====
`default_nettype none
interface swmb_in_if;
	import swmb_pkg::*;
	logic     valid;
	logic     ready;
	request_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface swmb_out_if;
	import swmb_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface swmb_cfg_if;
	import swmb_pkg::*;
	logic       valid;
	logic       ready;
	cfg_write_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/swmb_div.sv =====
`default_nettype none
// Restoring divider: one quotient bit per cycle.
module swmb_div
	import swmb_pkg::*;
#(
	parameter int unsigned NW = 20,
	parameter int unsigned DW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int unsigned CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits = trial >= {1'b0, den_q};
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/star_weighted_mean_blur_core.sv =====
`default_nettype none
// Star weighted mean blur, streaming over a line store with one write port and one read port.
// Steps per request: a pixel is written and checked against the output lag, then the walk
// visits each neighbor (address, read, accumulate inside the frame; address only outside),
// three 20-bit divides run, and the result is registered; a drain request skips the lag check.
// Flow: one request at a time; a pixel that causes no result returns to idle after the lag check.
// Reset: asynchronous, active low; R=1, weight 1, 640x480, frame counters zero, store kept.
module star_weighted_mean_blur_core
	import swmb_pkg::*;
#(
	parameter int unsigned MAX_RADIUS = 4,
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	swmb_in_if.sink   in_ch,
	swmb_out_if.source out_ch,
	swmb_cfg_if.sink  cfg
);
	localparam int unsigned DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
	localparam int unsigned CLW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned LW = 26; // frame linear position, up to MAX_WIDTH*MAX_HEIGHT
	localparam int unsigned NW = 20; // channel sum
	localparam int unsigned KW = $clog2(8 * MAX_RADIUS + 256);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_CHECK = 8'b00000010,
		ST_ADDR = 8'b00000100,
		ST_READ = 8'b00001000,
		ST_ACC = 8'b00010000,
		ST_DIV = 8'b00100000,
		ST_WAIT = 8'b01000000,
		ST_OUT = 8'b10000000
	} state_t;

	state_t state_q;

	// Registers
	logic [2:0]  radius_q;
	logic [7:0]  cweight_q;
	logic [10:0] width_q;
	logic [12:0] height_q;

	// Effective values
	logic [RW-1:0]  rad;
	logic [7:0]     cw;
	logic [CLW-1:0] w;
	logic [12:0]    h;
	always_comb begin
		rad = (radius_q == 3'd0) ? RW'(1) :
			(32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
		cw = (cweight_q == 8'd0) ? 8'd1 : cweight_q;
		w = (width_q == 11'd0) ? CLW'(1) :
			(32'(width_q) > MAX_WIDTH) ? CLW'(MAX_WIDTH) : CLW'(width_q);
		h = (height_q == 13'd0) ? 13'd1 : (32'(height_q) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_q;
	end

	// Frame size and output lag follow the registers without delay, so a request
	// right after a register write already sees the new frame.
	logic [LW-1:0] frame_total;   // w*h
	logic [LW-1:0] frame_lag;     // rad*w + rad
	assign frame_total = LW'(w) * LW'(h);
	assign frame_lag = LW'(rad) * LW'(w) + LW'(rad);

	// Frame state
	logic [AW-1:0]  wr_ptr_q;
	logic [LW-1:0]  taken_q;
	logic [LW-1:0]  out_lin_q;
	logic [12:0]    out_row_q;
	logic [CLW-1:0] out_col_q;
	logic           in_done_q;

	// Neighbor walk
	logic [RW-1:0] r_q;
	logic [3:0]    dir_q;   // 8 means centre
	logic signed [14:0] nr_q;
	logic signed [CLW+1:0] nc_q;
	logic [AW-1:0] addr_q;
	logic          first_q;
	logic [NW-1:0] sr_q, sg_q, sb_q;
	logic [KW-1:0] wsum_q;
	logic [1:0]    ch_q;
	logic [7:0]    qr_q, qg_q, qb_q;
	logic          last_q;
	result_t       res_q;
	logic          res_v_q;

	// Line store
	logic [23:0] mem [DEPTH];
	logic [23:0] rd_s1;
	logic        mem_we;
	logic [23:0] mem_wd;

	// Take a request whenever idle; a finished result waits in res_q while the
	// next request is processed. Register writes wait until nothing is in flight.
	logic in_fire, cfg_fire;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = (state_q == ST_IDLE) && !res_v_q && !in_ch.valid;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign out_ch.valid = res_v_q;
	assign out_ch.payload = res_q;

	assign mem_we = in_fire && in_ch.payload.func == FUNC_PIXEL && !in_done_q;
	assign mem_wd = {in_ch.payload.red, in_ch.payload.green, in_ch.payload.blue};

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_ptr_q] <= mem_wd;
		rd_s1 <= mem[addr_q];
	end

	logic inside_q;

	// Divider
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	swmb_div #(.NW(NW), .DW(KW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(wsum_q), .done(div_done), .quo(div_quo)
	);
	assign div_start = (state_q == ST_DIV);
	always_comb begin
		case (ch_q)
			2'd0: div_num = sr_q;
			2'd1: div_num = sg_q;
			default: div_num = sb_q;
		endcase
	end

	// back distance from newest: taken-1-lin; lin = nr*w + nc, with nr*w registered first.
	// Every read lies within 2*R*W + 2*R of the newest pixel, so back never wraps the store.
	logic [LW-1:0] lin_s;
	logic [LW-1:0] back_s;
	logic [LW-1:0] mul_q;
	logic          mphase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			radius_q <= 3'd1;
			cweight_q <= 8'd1;
			width_q <= 11'd640;
			height_q <= 13'd480;
			wr_ptr_q <= '0;
			taken_q <= '0;
			out_lin_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_done_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			// Load the output register from ST_OUT once it is free; drop it when taken.
			if (state_q == ST_OUT && (!res_v_q || out_ch.ready)) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						case (reg_idx_t'(cfg.payload.index))
							REG_RADIUS: radius_q <= cfg.payload.data[2:0];
							REG_CWEIGHT: cweight_q <= cfg.payload.data[7:0];
							REG_WIDTH: width_q <= cfg.payload.data[10:0];
							default: height_q <= cfg.payload.data;
						endcase
						taken_q <= '0; in_done_q <= 1'b0;
						out_lin_q <= '0; out_row_q <= '0; out_col_q <= '0;
					end else if (in_fire) begin
						if (mem_we) begin
							wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
							taken_q <= taken_q + 1'b1;
							if (taken_q + 1'b1 >= frame_total) in_done_q <= 1'b1;
							state_q <= ST_CHECK;
						end else if (in_done_q) begin
							state_q <= ST_ADDR;
						end
					end
				end
				ST_CHECK: begin
					state_q <= (taken_q - 1'b1 >= out_lin_q + frame_lag) ? ST_ADDR : ST_IDLE;
				end
				ST_ADDR: begin
					// compute linear position: first the row product, then the store address
					if (!mphase_q) begin
						state_q <= ST_ADDR;
					end else if (!inside_q && !first_q) begin
						state_q <= (dir_q == 4'd7 && r_q == rad) ? ST_DIV : ST_ADDR;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_ACC;
				ST_ACC: state_q <= (dir_q == 4'd7 && r_q == rad) ? ST_DIV : ST_ADDR;
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: if (div_done) state_q <= (ch_q == 2'd2) ? ST_OUT : ST_DIV;
				ST_OUT: begin
					// hold here while the previous result is still waiting
					if (!res_v_q || out_ch.ready) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							taken_q <= '0; in_done_q <= 1'b0;
							out_lin_q <= '0; out_row_q <= '0; out_col_q <= '0;
						end else begin
							out_lin_q <= out_lin_q + 1'b1;
							if (out_col_q + 1'b1 >= w) begin
								out_col_q <= '0; out_row_q <= out_row_q + 1'b1;
							end else out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb lin_s = mul_q + LW'(nc_q);
	assign back_s = taken_q - 1'b1 - lin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mphase_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CHECK, ST_IDLE: begin
					mphase_q <= 1'b0;
					first_q <= 1'b1;
				end
				ST_ADDR: begin
					mphase_q <= ~mphase_q;
					if (mphase_q && !inside_q && !first_q) first_q <= 1'b0;
				end
				ST_ACC: first_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE, ST_CHECK: begin
				r_q <= RW'(1); dir_q <= 4'd8;
				nr_q <= $signed({2'b0, out_row_q}); nc_q <= $signed({2'b0, out_col_q});
				sr_q <= '0; sg_q <= '0; sb_q <= '0;
				wsum_q <= KW'(cw);
				ch_q <= 2'd0;
				last_q <= (out_lin_q == frame_total - 1'b1);
			end
			ST_ADDR: begin
				if (!mphase_q) begin
					mul_q <= LW'(nr_q[12:0]) * LW'(w);
					inside_q <= nr_q >= 0 && nc_q >= 0 && nr_q < $signed({2'b0, h}) &&
						nc_q < $signed({2'b0, w});
				end else begin
					// newest pixel sits just below wr_ptr; step back and wrap once
					addr_q <= (LW'(wr_ptr_q) > back_s) ? AW'(LW'(wr_ptr_q) - back_s - 1'b1) :
						AW'(LW'(wr_ptr_q) + LW'(DEPTH) - back_s - 1'b1);
					if (!inside_q && !first_q) begin
						if (dir_q == 4'd7) begin r_q <= r_q + 1'b1; dir_q <= 4'd0; end
						else dir_q <= dir_q + 1'b1;
						nr_q <= cand_next_r(); nc_q <= cand_next_c();
					end
				end
			end
			ST_ACC: begin
				sr_q <= sr_q + (first_q ? NW'(rd_s1[23:16]) * NW'(cw) : NW'(rd_s1[23:16]));
				sg_q <= sg_q + (first_q ? NW'(rd_s1[15:8]) * NW'(cw) : NW'(rd_s1[15:8]));
				sb_q <= sb_q + (first_q ? NW'(rd_s1[7:0]) * NW'(cw) : NW'(rd_s1[7:0]));
				if (!first_q) wsum_q <= wsum_q + 1'b1;
				if (first_q) begin dir_q <= 4'd0; end
				else if (dir_q == 4'd7) begin r_q <= r_q + 1'b1; dir_q <= 4'd0; end
				else dir_q <= dir_q + 1'b1;
				nr_q <= cand_next_r(); nc_q <= cand_next_c();
			end
			ST_WAIT: if (div_done) begin
				case (ch_q)
					2'd0: qr_q <= div_quo[7:0];
					2'd1: qg_q <= div_quo[7:0];
					default: qb_q <= div_quo[7:0];
				endcase
				ch_q <= ch_q + 1'b1;
			end
			ST_OUT: if (!res_v_q || out_ch.ready)
				res_q <= '{out_red: qr_q, out_green: qg_q, out_blue: qb_q, frame_end: last_q};
			default: ;
		endcase
	end

	// Next neighbor coordinates after the current step
	function automatic logic signed [14:0] cand_next_r();
		logic [3:0] nd;
		logic [RW-1:0] nrr;
		logic signed [1:0] ndr;
		nd = (first_q || dir_q == 4'd7) ? 4'd0 : dir_q + 1'b1;
		nrr = (!first_q && dir_q == 4'd7) ? r_q + 1'b1 : r_q;
		ndr = (nd < 4'd3) ? -2'sd1 : (nd < 4'd5) ? 2'sd0 : 2'sd1;
		return $signed({2'b0, out_row_q}) + 15'(ndr) * $signed(15'(nrr));
	endfunction

	function automatic logic signed [CLW+1:0] cand_next_c();
		logic [3:0] nd;
		logic [RW-1:0] nrr;
		logic signed [1:0] ndc;
		nd = (first_q || dir_q == 4'd7) ? 4'd0 : dir_q + 1'b1;
		nrr = (!first_q && dir_q == 4'd7) ? r_q + 1'b1 : r_q;
		ndc = (nd == 4'd0 || nd == 4'd3 || nd == 4'd5) ? -2'sd1 :
			(nd == 4'd1 || nd == 4'd6) ? 2'sd0 : 2'sd1;
		return $signed({2'b0, out_col_q}) + (CLW+2)'(ndc) * $signed((CLW+2)'(nrr));
	endfunction
endmodule
`default_nettype wire
